// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the sum tree sampler.
// STWS_ASSERT expects clk_i and rst_ni, STWS_ASSERT_ALWAYS clk_i, to be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define STWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define STWS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/stws_pkg.sv =====
// Shared types and constants of the sum tree weighted sampler.
// No dependencies; every module and interface file of the block imports this package.
package stws_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IDX_IN_W    = 10;
  localparam int unsigned DELTA_W     = 32;
  localparam int unsigned WEIGHT_IN_W = 32;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned ERR_W       = 2;

  // Signed working width for changes, new leaf values and new totals.
  localparam int unsigned CHG_W = SUM_W + 2;

  // Defaults for the top level parameters.
  localparam int unsigned LEAVES_DEF      = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 32;
  localparam int unsigned NODE_AW_DEF     = $clog2(LEAVES_DEF) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD,
    CMD_SET,
    CMD_SAMPLE,
    CMD_PREFIX
  } stws_cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK,
    ERR_RANGE,
    ERR_DRAW
  } stws_err_e;

  typedef struct packed {
    stws_cmd_e                  cmd;
    logic [IDX_IN_W-1:0]        leaf_index;
    logic signed [DELTA_W-1:0]  delta;
    logic [WEIGHT_IN_W-1:0]     new_weight;
    logic [SUM_W-1:0]           draw;
    logic [IDX_IN_W-1:0]        prefix_count;
  } stws_req_t;

  typedef struct packed {
    logic [IDX_IN_W-1:0] chosen_leaf;
    logic [SUM_W-1:0]    prefix_sum;
    logic [SUM_W-1:0]    total_sum;
    stws_err_e           error;
  } stws_res_t;

endpackage

// ===== hdl/stws_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
// Depends on stws_pkg for the field widths.
interface stws_req_if import stws_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [IDX_IN_W-1:0]       leaf_index;
  logic signed [DELTA_W-1:0] delta;
  logic [WEIGHT_IN_W-1:0]    new_weight;
  logic [SUM_W-1:0]          draw;
  logic [IDX_IN_W-1:0]       prefix_count;

  modport source (
    output valid, cmd, leaf_index, delta, new_weight, draw, prefix_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, leaf_index, delta, new_weight, draw, prefix_count,
    output ready
  );
endinterface

interface stws_rsp_if import stws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_IN_W-1:0] chosen_leaf;
  logic [SUM_W-1:0]    prefix_sum;
  logic [SUM_W-1:0]    total_sum;
  logic [ERR_W-1:0]    error;

  modport source (
    output valid, chosen_leaf, prefix_sum, total_sum, error,
    input  ready
  );
  modport sink (
    input  valid, chosen_leaf, prefix_sum, total_sum, error,
    output ready
  );
endinterface

// ===== hdl/sum_tree_weighted_sampler.sv =====
// Weighted sampler over a binary sum tree kept in one simple dual-port RAM.
// Add and set: a leaf read, a range check, then one RAM write per level below the root.
// Sample and prefix: one read per level. Errors found at decode answer without a RAM
// access, a range-check refusal after the leaf read. A new request is taken only once
// the last result has been handed on. Reset clears the RAM one node per cycle, with
// ready held low.
module sum_tree_weighted_sampler import stws_pkg::*; #(
  parameter int unsigned LEAVES      = LEAVES_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stws_req_if.sink   req_i,
  stws_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(LEAVES) + 1;

  stws_req_t        req;
  stws_res_t        res;
  logic             res_valid;
  logic             res_ready;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [SUM_W-1:0] mem_rdata;
  logic             out_valid_q;
  stws_res_t        out_q;

  assign req.cmd          = stws_cmd_e'(req_i.cmd);
  assign req.leaf_index   = req_i.leaf_index;
  assign req.delta        = req_i.delta;
  assign req.new_weight   = req_i.new_weight;
  assign req.draw         = req_i.draw;
  assign req.prefix_count = req_i.prefix_count;

  stws_engine #(
    .LEAVES      (LEAVES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (req),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  stws_ram #(
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: the engine may hand over a new result in the cycle the
  // current one is taken.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.chosen_leaf = out_q.chosen_leaf;
  assign rsp_o.prefix_sum  = out_q.prefix_sum;
  assign rsp_o.total_sum   = out_q.total_sum;
  assign rsp_o.error       = out_q.error;

endmodule

// ===== hdl/stws_ram.sv =====
// Simple dual-port node memory of the sum tree, with registered read data.
// Depends on stws_pkg for the node sum width.
module stws_ram import stws_pkg::*; #(
  parameter int unsigned ADDR_W = NODE_AW_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [SUM_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [SUM_W-1:0]  rdata_o
);

  logic [SUM_W-1:0] mem_q [2**ADDR_W];
  logic [SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/stws_engine.sv =====
// Command sequencer of the sum tree sampler: clears the node memory, walks it
// level by level for updates, samples and prefix sums. Depends on stws_pkg.
module stws_engine import stws_pkg::*; #(
  parameter int unsigned LEAVES      = LEAVES_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int unsigned IDX_W      = $clog2(LEAVES),
  localparam int unsigned AW         = IDX_W + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  stws_req_t        req_i,
  output logic             req_ready_o,
  output logic             res_valid_o,
  output stws_res_t        res_o,
  input  logic             res_ready_i,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic [SUM_W-1:0] mem_wdata_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  logic [SUM_W-1:0] mem_rdata_i
);

  localparam int unsigned LW = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
  localparam logic [LW:0] LEAVES_L = (LW + 1)'(LEAVES);
  localparam logic [IDX_IN_W-1:0] LAST_LEAF = IDX_IN_W'(LEAVES - 1);
  localparam logic signed [CHG_W-1:0] WEIGHT_MAX =
      CHG_W'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic signed [CHG_W-1:0] SUM_MAX = CHG_W'((64'd1 << SUM_W) - 64'd1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_CHECK,
    ST_UPD_WALK,
    ST_SAMPLE,
    ST_PREFIX,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [AW-1:0]             clr_addr_q;
  logic [AW-1:0]             node_q;
  logic [SUM_W-1:0]          x_q;
  logic [SUM_W-1:0]          acc_q;
  logic [SUM_W-1:0]          total_q;
  logic [IDX_W-1:0]          p_q;
  logic signed [CHG_W-1:0]   change_q;
  logic signed [CHG_W-1:0]   leaf_new_q;
  stws_cmd_e                 cmd_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [WEIGHT_IN_W-1:0]    weight_q;
  stws_res_t                 res_q;

  // Request decode.
  logic [LW-1:0]    leaf_wide;
  logic [LW-1:0]    count_wide;
  logic [IDX_W-1:0] leaf_idx;
  logic [IDX_W-1:0] count_idx;
  logic             upd_refused;
  logic             draw_big;
  logic             count_big;

  assign leaf_wide   = LW'(req_i.leaf_index);
  assign count_wide  = LW'(req_i.prefix_count);
  assign leaf_idx    = leaf_wide[IDX_W-1:0];
  assign count_idx   = count_wide[IDX_W-1:0];
  assign count_big   = {1'b0, count_wide} >= LEAVES_L;
  assign draw_big    = req_i.draw >= total_q;
  assign upd_refused = ({1'b0, leaf_wide} >= LEAVES_L) ||
                       ((req_i.cmd == CMD_SET) &&
                        (CHG_W'(req_i.new_weight) > CHG_W'(WEIGHT_MAX)));

  // Update arithmetic: the leaf value is on the read port in ST_UPD_LEAF.
  logic signed [CHG_W-1:0] leaf_old;
  logic signed [CHG_W-1:0] delta_ext;
  logic signed [CHG_W-1:0] weight_ext;
  logic signed [CHG_W-1:0] change_calc;
  logic signed [CHG_W-1:0] leaf_new_calc;
  logic signed [CHG_W-1:0] new_total;
  logic                    upd_ok;
  logic [AW-1:0]           parent;
  logic                    parent_is_root;

  assign leaf_old      = $signed(CHG_W'(mem_rdata_i));
  assign delta_ext     = CHG_W'(delta_q);
  assign weight_ext    = $signed(CHG_W'(weight_q));
  assign change_calc   = (cmd_q == CMD_ADD) ? delta_ext : weight_ext - leaf_old;
  assign leaf_new_calc = (cmd_q == CMD_ADD) ? leaf_old + delta_ext : weight_ext;
  assign new_total     = $signed(CHG_W'(total_q)) + change_q;
  assign upd_ok        = !leaf_new_q[CHG_W-1] && (leaf_new_q <= WEIGHT_MAX) &&
                         !new_total[CHG_W-1] && (new_total <= SUM_MAX);
  assign parent         = node_q >> 1;
  assign parent_is_root = parent == AW'(1);

  // Downward walk: the left child of node_q is on the read port.
  logic             sel_right;
  logic [AW-1:0]    child;
  logic [SUM_W-1:0] x_next;
  logic [SUM_W-1:0] acc_next;
  logic [LW-1:0]    chosen_wide;

  assign sel_right   = (state_q == ST_SAMPLE) ? (x_q >= mem_rdata_i) : p_q[IDX_W-1];
  assign child       = {node_q[IDX_W-1:0], sel_right};
  assign x_next      = x_q - mem_rdata_i;
  assign acc_next    = acc_q + mem_rdata_i;
  assign chosen_wide = LW'(child[IDX_W-1:0]);

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = node_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = parent;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_addr_q;
      end
      ST_IDLE: begin
        priority if ((req_i.cmd == CMD_ADD) || (req_i.cmd == CMD_SET)) begin
          mem_raddr_o = {1'b1, leaf_idx};
          mem_re_o    = req_valid_i && !upd_refused;
        end else if (req_i.cmd == CMD_SAMPLE) begin
          mem_raddr_o = AW'(2);
          mem_re_o    = req_valid_i && !draw_big;
        end else begin
          mem_raddr_o = AW'(2);
          mem_re_o    = req_valid_i && !count_big;
        end
      end
      ST_UPD_CHECK: begin
        mem_we_o    = upd_ok;
        mem_wdata_o = leaf_new_q[SUM_W-1:0];
        mem_re_o    = upd_ok && !parent_is_root;
      end
      ST_UPD_WALK: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i + change_q[SUM_W-1:0];
        mem_re_o    = !parent_is_root;
      end
      ST_SAMPLE, ST_PREFIX: begin
        mem_re_o    = !child[IDX_W];
        mem_raddr_o = {child[IDX_W-1:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      node_q     <= '0;
      x_q        <= '0;
      acc_q      <= '0;
      total_q    <= '0;
      p_q        <= '0;
      change_q   <= '0;
      leaf_new_q <= '0;
      cmd_q      <= CMD_ADD;
      delta_q    <= '0;
      weight_q   <= '0;
      res_q      <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (&clr_addr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid_i) begin
            cmd_q             <= req_i.cmd;
            delta_q           <= req_i.delta;
            weight_q          <= req_i.new_weight;
            x_q               <= req_i.draw;
            p_q               <= count_idx;
            acc_q             <= '0;
            node_q            <= AW'(1);
            res_q.chosen_leaf <= '0;
            res_q.prefix_sum  <= '0;
            res_q.total_sum   <= total_q;
            res_q.error       <= ERR_OK;
            unique case (req_i.cmd)
              CMD_ADD, CMD_SET: begin
                if (upd_refused) begin
                  res_q.error <= ERR_RANGE;
                  state_q     <= ST_DONE;
                end else begin
                  node_q  <= {1'b1, leaf_idx};
                  state_q <= ST_UPD_LEAF;
                end
              end
              CMD_SAMPLE: begin
                if (draw_big) begin
                  res_q.chosen_leaf <= LAST_LEAF;
                  res_q.error       <= ERR_DRAW;
                  state_q           <= ST_DONE;
                end else begin
                  state_q <= ST_SAMPLE;
                end
              end
              CMD_PREFIX: begin
                if (count_big) begin
                  res_q.prefix_sum <= total_q;
                  state_q          <= ST_DONE;
                end else begin
                  state_q <= ST_PREFIX;
                end
              end
            endcase
          end
        end
        ST_UPD_LEAF: begin
          change_q   <= change_calc;
          leaf_new_q <= leaf_new_calc;
          state_q    <= ST_UPD_CHECK;
        end
        ST_UPD_CHECK: begin
          if (upd_ok) begin
            total_q         <= new_total[SUM_W-1:0];
            res_q.total_sum <= new_total[SUM_W-1:0];
            node_q          <= parent;
            state_q         <= parent_is_root ? ST_DONE : ST_UPD_WALK;
          end else begin
            res_q.error <= ERR_RANGE;
            state_q     <= ST_DONE;
          end
        end
        ST_UPD_WALK: begin
          // The root is kept in total_q, so the walk ends below it.
          node_q <= parent;
          if (parent_is_root) begin
            state_q <= ST_DONE;
          end
        end
        ST_SAMPLE: begin
          if (sel_right) begin
            x_q <= x_next;
          end
          node_q <= child;
          if (child[IDX_W]) begin
            res_q.chosen_leaf <= chosen_wide[IDX_IN_W-1:0];
            state_q           <= ST_DONE;
          end
        end
        ST_PREFIX: begin
          if (sel_right) begin
            acc_q <= acc_next;
          end
          p_q    <= p_q << 1;
          node_q <= child;
          if (child[IDX_W]) begin
            res_q.prefix_sum <= sel_right ? acc_next : acc_q;
            state_q          <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;
  assign res_o       = res_q;

endmodule

// ===== hdl/stws_checker.sv =====
// Port-level assertions for the sum tree sampler, bound to its top level.
// Depends on stws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stws_checker import stws_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [IDX_IN_W-1:0] rsp_chosen_leaf_i,
  input logic [SUM_W-1:0]    rsp_prefix_sum_i,
  input logic [SUM_W-1:0]    rsp_total_sum_i,
  input logic [ERR_W-1:0]    rsp_error_i
);

  logic rsp_stalled;
  logic rsp_refused;
  logic rsp_no_data;

  assign rsp_stalled = rsp_valid_i && !rsp_ready_i;
  assign rsp_refused = rsp_valid_i && (rsp_error_i == ERR_RANGE);
  assign rsp_no_data = (rsp_chosen_leaf_i == '0) && (rsp_prefix_sum_i == '0);

  // Nothing is taken or offered while reset holds.
  `STWS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !req_ready_i && !rsp_valid_i, "active in reset")

  // One request at a time: the block is busy in the cycle after an accept.
  `STWS_ASSERT(a_busy_after_req, req_valid_i && req_ready_i |=> !req_ready_i, "ready after accept")

  // A refused update reports neither a leaf nor a prefix sum.
  `STWS_ASSERT(a_refused_clean, rsp_refused |-> rsp_no_data, "refused update carries data")

  `STWS_ASSERT(a_rsp_hold, rsp_stalled |=> rsp_valid_i && $stable(rsp_total_sum_i), "held result moved")

endmodule

bind sum_tree_weighted_sampler stws_checker u_stws_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_chosen_leaf_i (rsp_o.chosen_leaf),
  .rsp_prefix_sum_i  (rsp_o.prefix_sum),
  .rsp_total_sum_i   (rsp_o.total_sum),
  .rsp_error_i       (rsp_o.error)
);
